// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder back end (scdec_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ant holds.
`define ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ant holds.
`define ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/scdec_pkg.sv =====
// Types, scancode constants and key map of the Set 1 scancode decoder.
package scdec_pkg;

	localparam logic [7:0] SC_PREFIX = 8'hE0;
	localparam logic [7:0] SC_PGUP   = 8'h49;
	localparam logic [7:0] SC_PGDN   = 8'h51;
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_ENTER  = 7'h1C;
	localparam logic [6:0] SC_BKSP   = 7'h0E;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_PGUP,
		OP_PGDN,
		OP_READ
	} op_kind_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_QUEUED,
		EV_DROPPED,
		EV_PGUP,
		EV_PGDN
	} ev_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [6:0] ch;
	} op_t;

	function automatic logic [6:0] map_key(input logic [6:0] code, input logic shift);
		logic [6:0] ch;
		case (code)
			SC_ENTER: ch = 7'h0A;
			SC_BKSP:  ch = 7'h08;
			7'h1E: ch = 7'h61;
			7'h30: ch = 7'h62;
			7'h2E: ch = 7'h63;
			7'h20: ch = 7'h64;
			7'h12: ch = 7'h65;
			7'h21: ch = 7'h66;
			7'h22: ch = 7'h67;
			7'h23: ch = 7'h68;
			7'h17: ch = 7'h69;
			7'h24: ch = 7'h6A;
			7'h25: ch = 7'h6B;
			7'h26: ch = 7'h6C;
			7'h32: ch = 7'h6D;
			7'h31: ch = 7'h6E;
			7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;
			7'h10: ch = 7'h71;
			7'h13: ch = 7'h72;
			7'h1F: ch = 7'h73;
			7'h14: ch = 7'h74;
			7'h16: ch = 7'h75;
			7'h2F: ch = 7'h76;
			7'h11: ch = 7'h77;
			7'h2D: ch = 7'h78;
			7'h15: ch = 7'h79;
			7'h2C: ch = 7'h7A;
			7'h0B: ch = 7'h30;
			7'h02: ch = 7'h31;
			7'h03: ch = 7'h32;
			7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;
			7'h06: ch = 7'h35;
			7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;
			7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39;
			7'h39: ch = 7'h20;
			7'h0C: ch = shift ? 7'h5F : 7'h2D;
			7'h33: ch = shift ? 7'h3C : 7'h2C;
			7'h34: ch = shift ? 7'h3E : 7'h2E;
			7'h35: ch = 7'h2F;
			7'h2B: ch = shift ? 7'h7C : 7'h5C;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/core/scdec_front.sv =====
// Front end: tracks prefix, shift and key-down bits and classifies each beat.
module scdec_front
	import scdec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_func,
	input  logic [7:0] in_code,
	input  logic       q_ready,
	output logic       q_valid,
	output op_t        q_op
);

	logic         prefix_q;
	logic         shift_q;
	logic [127:0] keys_held_q;
	logic         accept;
	logic [6:0]   low7;
	logic         is_shift;
	logic [6:0]   mapped;

	assign accept   = in_valid & q_ready;
	assign q_valid  = in_valid;
	assign low7     = in_code[6:0];
	assign is_shift = (low7 == SC_LSHIFT) || (low7 == SC_RSHIFT);
	assign mapped   = map_key(low7, shift_q);

	always_comb begin
		q_op.kind = OP_NONE;
		q_op.ch   = mapped;
		if (in_func) begin
			q_op.kind = OP_READ;
		end else if (in_code == SC_PREFIX) begin
			q_op.kind = OP_NONE;
		end else if (prefix_q) begin
			if (in_code == SC_PGUP) begin
				q_op.kind = OP_PGUP;
			end else if (in_code == SC_PGDN) begin
				q_op.kind = OP_PGDN;
			end
		end else if (!in_code[7] && !keys_held_q[low7] && !is_shift && (mapped != 7'h00)) begin
			q_op.kind = OP_PUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q    <= 1'b0;
			shift_q     <= 1'b0;
			keys_held_q <= '0;
		end else if (accept && !in_func) begin
			if (in_code == SC_PREFIX) begin
				prefix_q <= 1'b1;
			end else if (prefix_q) begin
				prefix_q <= 1'b0;
			end else if (in_code[7]) begin
				keys_held_q[low7] <= 1'b0;
				if (is_shift) begin
					shift_q <= 1'b0;
				end
			end else if (!keys_held_q[low7]) begin
				keys_held_q[low7] <= 1'b1;
				if (is_shift) begin
					shift_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/scdec_queue.sv =====
// Two-entry operation queue between front and back end.
module scdec_queue
	import scdec_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	output logic out_valid,
	input  logic out_ready,
	output op_t  out_op
);

	op_t        entry_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_op    = entry_q[rd_idx_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/scdec_back.sv =====
// Back end: character ring buffer, pointer control and output register.
`include "assert_macros.svh"

module scdec_back
	import scdec_pkg::*;
#(
	parameter int FIFO_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	output logic       op_ready,
	input  op_t        op,
	output logic       out_valid,
	input  logic       out_ready,
	output ev_t        out_event,
	output logic       out_follow,
	output logic       out_read_valid,
	output logic [6:0] out_char
);

	localparam int ADDR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(FIFO_DEPTH - 1);

	logic [6:0]        mem [FIFO_DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W-1:0] wr_next;
	logic [ADDR_W-1:0] rd_next;
	logic              full;
	logic              empty;
	logic              adv;
	logic              do_push;
	logic              do_pop;
	ev_t               ev;
	logic              out_valid_q;
	ev_t               event_q;
	logic              follow_q;
	logic              read_valid_q;
	logic [6:0]        rd_data_q;

	assign wr_next  = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign full     = (wr_next == rd_ptr_q);
	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign adv      = op_valid & (~out_valid_q | out_ready);
	assign op_ready = adv;
	assign do_push  = adv & (op.kind == OP_PUSH) & ~full;
	assign do_pop   = adv & (op.kind == OP_READ) & ~empty;

	always_comb begin
		case (op.kind)
			OP_PUSH: ev = full ? EV_DROPPED : EV_QUEUED;
			OP_PGUP: ev = EV_PGUP;
			OP_PGDN: ev = EV_PGDN;
			default: ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= op.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_q      <= ev;
			follow_q     <= (op.kind == OP_PUSH);
			read_valid_q <= (op.kind == OP_READ) & ~empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_next;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_next;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_event      = event_q;
	assign out_follow     = follow_q;
	assign out_read_valid = read_valid_q;
	assign out_char       = read_valid_q ? rd_data_q : 7'h00;

	`ASSERT_SAME(a_wr_ptr_range, 1'b1, int'(wr_ptr_q) < FIFO_DEPTH, "write pointer out of range")
	`ASSERT_SAME(a_rd_ptr_range, 1'b1, int'(rd_ptr_q) < FIFO_DEPTH, "read pointer out of range")
	`ASSERT_NEXT(a_push_queued, do_push, out_valid_q && (event_q == EV_QUEUED),
		"accepted push not reported as queued")
	`ASSERT_NEXT(a_empty_read, adv && (op.kind == OP_READ) && empty,
		out_valid_q && !read_valid_q && (out_char == 7'h00), "read on empty returned data")

endmodule

// ===== rtl/core/scancode_set1_key_decoder_fifo_top.sv =====
// Top level of the Set 1 scancode decoder with character FIFO.
// Input beats carry either a scancode byte (tuser = 0, byte in tdata) or a
// read request (tuser = 1). Every accepted beat yields exactly one output beat
// with event code, follow flag and, for reads, the popped character.
// The front end updates prefix, shift and 128 key-down bits in the cycle a
// beat is accepted and hands a classified operation to a two-entry queue.
// The back end takes one operation per cycle from the queue while its output
// register is free or being taken, updates the ring buffer pointers and loads
// the output register; read data comes from the registered memory read port
// of the buffer. An input beat passes the queue entry and then the output register.
// Throughput: one beat per cycle while the receiver takes every output beat.
// The buffer holds FIFO_DEPTH-1 characters; a push into a full buffer drops
// the character and reports it.
// Reset clears prefix, shift, key-down bits, pointers and the queue; buffer
// contents are not cleared and no clearing pass is needed.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_axis_tready drops until the receiver takes beats again.
module scancode_set1_key_decoder_fifo_top
	import scdec_pkg::*;
#(
	parameter int FIFO_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] scan_code
	input  logic        s_axis_tuser,  // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [2:0] event_res, [3] follow_latest,
	                                   // [4] read_valid, [11:5] popped_char, [15:12] zero
);

	logic       fq_valid;
	logic       fq_ready;
	op_t        fq_op;
	logic       qb_valid;
	logic       qb_ready;
	op_t        qb_op;
	ev_t        event_res;
	logic       follow_latest;
	logic       read_valid;
	logic [6:0] popped_char;

	scdec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_code  (s_axis_tdata),
		.q_ready  (fq_ready),
		.q_valid  (fq_valid),
		.q_op     (fq_op)
	);

	scdec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_op     (fq_op),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_op    (qb_op)
	);

	scdec_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.op_valid       (qb_valid),
		.op_ready       (qb_ready),
		.op             (qb_op),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_event      (event_res),
		.out_follow     (follow_latest),
		.out_read_valid (read_valid),
		.out_char       (popped_char)
	);

	assign s_axis_tready = fq_ready;
	assign m_axis_tdata  = {4'b0000, popped_char, read_valid, follow_latest, event_res};

endmodule

// ===== dv/tb_scancode_set1_key_decoder_fifo_top.sv =====
// Testbench for the Set 1 scancode decoder: predicts every output beat and checks it.
`timescale 1ns / 1ps

module tb_scancode_set1_key_decoder_fifo_top;
	import scdec_pkg::*;

	localparam int FIFO_DEPTH = 128;
	localparam int CHAR_CAPACITY = FIFO_DEPTH - 1;
	localparam int NUM_KEYS = 44;
	localparam int NUM_PRINTABLE = 42;
	localparam logic [6:0] NEWLINE_CHAR = 7'h0A;
	localparam logic [6:0] BACKSPACE_CHAR = 7'h08;
	localparam logic [7:0] RELEASE_BIT = 8'h80;

	typedef struct {
		ev_t        ev;
		logic       follow;
		logic       rvalid;
		logic [6:0] rchar;
	} out_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] scan_code
	logic        s_axis_tuser;  // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // [2:0] event_res, [3] follow_latest, [4] read_valid,
	                            // [11:5] popped_char, [15:12] zero

	logic [6:0] plain_ascii [128];
	logic [6:0] shifted_ascii [128];
	logic [6:0] key_codes [NUM_KEYS];
	bit         keys_held [128];
	bit         shift_on;
	bit         prefix_on;
	logic [6:0] char_fifo [$];
	out_beat_t  expected_beats [$];

	bit src_idle;
	bit snk_idle;
	int beats_sent;
	int mismatch_count;

	scancode_set1_key_decoder_fifo_top #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic void init_keymap();
		string key_chars;
		byte   c;
		key_chars = "abcdefghijklmnopqrstuvwxyz0123456789 -,./\\";
		key_codes = '{7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17,
			7'h24, 7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1F,
			7'h14, 7'h16, 7'h2F, 7'h11, 7'h2D, 7'h15, 7'h2C,
			7'h0B, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0A,
			7'h39, 7'h0C, 7'h33, 7'h34, 7'h35, 7'h2B, SC_ENTER, SC_BKSP};
		for (int i = 0; i < 128; i++)
			plain_ascii[i] = 7'd0;
		for (int i = 0; i < NUM_PRINTABLE; i++) begin
			c = key_chars.getc(i);
			plain_ascii[key_codes[i]] = c[6:0];
		end
		plain_ascii[SC_ENTER] = NEWLINE_CHAR;
		plain_ascii[SC_BKSP] = BACKSPACE_CHAR;
		shifted_ascii = plain_ascii;
		key_chars = "_<>|";
		c = key_chars.getc(0);
		shifted_ascii[7'h0C] = c[6:0];
		c = key_chars.getc(1);
		shifted_ascii[7'h33] = c[6:0];
		c = key_chars.getc(2);
		shifted_ascii[7'h34] = c[6:0];
		c = key_chars.getc(3);
		shifted_ascii[7'h2B] = c[6:0];
	endfunction

	function automatic out_beat_t decode_beat(input logic func, input logic [7:0] code);
		out_beat_t  res;
		logic [6:0] key;
		logic [6:0] ch;
		res.ev = EV_NONE;
		res.follow = 1'b0;
		res.rvalid = 1'b0;
		res.rchar = 7'd0;
		key = code[6:0];
		ch = 7'd0;
		if (func) begin
			if (char_fifo.size() != 0) begin
				res.rvalid = 1'b1;
				res.rchar = char_fifo.pop_front();
			end
		end else if (code == SC_PREFIX) begin
			prefix_on = 1'b1;
		end else if (prefix_on) begin
			prefix_on = 1'b0;
			if (code == SC_PGUP)
				res.ev = EV_PGUP;
			else if (code == SC_PGDN)
				res.ev = EV_PGDN;
		end else if (code[7]) begin
			keys_held[key] = 1'b0;
			if (key == SC_LSHIFT || key == SC_RSHIFT)
				shift_on = 1'b0;
		end else if (!keys_held[key]) begin
			keys_held[key] = 1'b1;
			if (key == SC_LSHIFT || key == SC_RSHIFT)
				shift_on = 1'b1;
			else
				ch = shift_on ? shifted_ascii[key] : plain_ascii[key];
			if (ch != 7'd0) begin
				res.follow = 1'b1;
				if (char_fifo.size() >= CHAR_CAPACITY) begin
					res.ev = EV_DROPPED;
				end else begin
					char_fifo.push_back(ch);
					res.ev = EV_QUEUED;
				end
			end
		end
		return res;
	endfunction

	task automatic send_beat(input logic func, input logic [7:0] code);
		int gap;
		gap = src_idle ? $urandom_range(18) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		s_axis_tuser <= func;
		do @(posedge clk); while (!s_axis_tready);
		expected_beats.push_back(decode_beat(func, code));
		beats_sent++;
	endtask

	task automatic type_key(input logic [6:0] key, input bit with_shift, input bit twice);
		logic [7:0] shift_code;
		shift_code = {1'b0, ($urandom_range(1) != 0) ? SC_LSHIFT : SC_RSHIFT};
		if (with_shift)
			send_beat(1'b0, shift_code);
		send_beat(1'b0, {1'b0, key});
		if (twice)
			send_beat(1'b0, {1'b0, key});
		send_beat(1'b0, {1'b0, key} | RELEASE_BIT);
		if (with_shift)
			send_beat(1'b0, shift_code | RELEASE_BIT);
	endtask

	task automatic page_key();
		send_beat(1'b0, SC_PREFIX);
		if ($urandom_range(99) < 20)
			send_beat(1'b0, SC_PREFIX);
		case ($urandom_range(4))
			0: send_beat(1'b0, SC_PGUP);
			1: send_beat(1'b0, SC_PGDN);
			2: send_beat(1'b0, SC_PGUP | RELEASE_BIT);
			3: send_beat(1'b0, SC_PGDN | RELEASE_BIT);
			default: send_beat(1'b0, 8'($urandom));
		endcase
	endtask

	task automatic flag_mismatch(input string field, input int exp_val, input int act_val);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
			act_val);
		mismatch_count++;
	endtask

	task automatic test_directed();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		send_beat(1'b1, 8'hFF);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'h7F);
		send_beat(1'b0, 8'hFF);
		send_beat(1'b0, 8'h80);
		send_beat(1'b0, 8'h1E);
		send_beat(1'b0, 8'h1E);
		send_beat(1'b0, 8'h9E);
		send_beat(1'b0, {1'b0, SC_LSHIFT});
		send_beat(1'b0, 8'h0C);
		send_beat(1'b0, 8'h8C);
		send_beat(1'b0, {1'b0, SC_LSHIFT} | RELEASE_BIT);
		send_beat(1'b0, {1'b0, SC_ENTER});
		send_beat(1'b0, {1'b0, SC_BKSP});
		send_beat(1'b0, SC_PREFIX);
		send_beat(1'b0, SC_PREFIX);
		send_beat(1'b0, SC_PGUP);
		send_beat(1'b0, SC_PREFIX);
		send_beat(1'b0, SC_PGDN);
		send_beat(1'b0, SC_PREFIX);
		send_beat(1'b0, SC_PGUP | RELEASE_BIT);
		send_beat(1'b0, SC_PREFIX);
		send_beat(1'b0, 8'h1E);
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'h5A);
	endtask

	task automatic test_fifo_full();
		src_idle = 1'b0;
		snk_idle = 1'b1;
		for (int i = 0; i < CHAR_CAPACITY + 4; i++)
			type_key(key_codes[$urandom_range(NUM_KEYS - 1)], 1'b0, 1'b0);
		src_idle = 1'b1;
		snk_idle = 1'b0;
		for (int i = 0; i < CHAR_CAPACITY + 4; i++)
			send_beat(1'b1, 8'($urandom));
	endtask

	task automatic test_random(input int n);
		int stop_at;
		int phase_end;
		int read_pct;
		int pick;
		logic [7:0] code;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			phase_end = beats_sent + 150;
			read_pct = $urandom_range(70, 5);
			case ($urandom_range(3))
				0: begin src_idle = 1'b1; snk_idle = 1'b1; end
				1: begin src_idle = 1'b1; snk_idle = 1'b0; end
				2: begin src_idle = 1'b0; snk_idle = 1'b1; end
				default: begin src_idle = 1'b0; snk_idle = 1'b0; end
			endcase
			while (beats_sent < phase_end && beats_sent < stop_at) begin
				pick = $urandom_range(99);
				if (pick < read_pct) begin
					send_beat(1'b1, 8'($urandom));
				end else begin
					pick = $urandom_range(99);
					if (pick < 60) begin
						type_key(key_codes[$urandom_range(NUM_KEYS - 1)],
							$urandom_range(99) < 30, $urandom_range(99) < 15);
					end else if (pick < 75) begin
						page_key();
					end else if (pick < 88) begin
						code = 8'($urandom_range(127));
						send_beat(1'b0, code);
						send_beat(1'b0, code | RELEASE_BIT);
					end else begin
						send_beat(1'b0, 8'($urandom));
					end
				end
			end
		end
	endtask

	initial begin : result_monitor
		out_beat_t exp_beat;
		int stall;
		wait (arst_n);
		forever begin
			stall = snk_idle ? $urandom_range(18) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (expected_beats.size() == 0) begin
				$display("%0t ns: unexpected output beat, expected none, actual %0h", $time,
					m_axis_tdata);
				mismatch_count++;
			end else begin
				exp_beat = expected_beats.pop_front();
				if (m_axis_tdata[2:0] != exp_beat.ev)
					flag_mismatch("event_res", exp_beat.ev, m_axis_tdata[2:0]);
				if (m_axis_tdata[3] != exp_beat.follow)
					flag_mismatch("follow_latest", exp_beat.follow, m_axis_tdata[3]);
				if (m_axis_tdata[4] != exp_beat.rvalid)
					flag_mismatch("read_valid", exp_beat.rvalid, m_axis_tdata[4]);
				if (m_axis_tdata[11:5] != exp_beat.rchar)
					flag_mismatch("popped_char", exp_beat.rchar, m_axis_tdata[11:5]);
			end
		end
	end

	initial begin : watchdog
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		beats_sent = 0;
		mismatch_count = 0;
		shift_on = 1'b0;
		prefix_on = 1'b0;
		for (int i = 0; i < 128; i++)
			keys_held[i] = 1'b0;
		init_keymap();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fifo_full();
		test_random(1400);
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
